FILE: rtl/fdm_pkg.sv
// Shared types and constants of the fractional-delay two-mic mixer.
package fdm_pkg;

  localparam int HIST_DEPTH  = 1024;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int FRAC_BITS   = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_BITS   = 15;
  localparam int GAIN_W      = 16;
  localparam int DELAY_W     = 18;
  localparam int NUM_PATHS   = 4;
  localparam int CFG_IDX_W   = 4;

  localparam int PA_W  = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int P_W   = PA_W + GAIN_W + 1;
  localparam int SHIFT = FRAC_BITS + GAIN_BITS;
  localparam int SH_W  = P_W - SHIFT;
  localparam int MIX_W = SAMPLE_BITS + 1;

  localparam int IN_W      = 2 * SAMPLE_BITS;
  localparam int OUT_BITS  = NUM_PATHS * SAMPLE_BITS + 2 * MIX_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [DELAY_W-1:0] MAX_DELAY =
    DELAY_W'(((HIST_DEPTH - 1) << FRAC_BITS) - 1);
  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1 << GAIN_BITS);
  localparam logic [HIST_AW:0] FILL_MAX = (HIST_AW + 1)'(HIST_DEPTH);
  localparam logic [P_W-1:0] ROUND_BIAS = P_W'(1) << (SHIFT - 1);
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_S0_M0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_S0_M1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_S1_M0 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_S1_M1 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_S0_M0  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_S0_M1  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_S1_M0  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_S1_M1  = 4'd7;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic               wr_en;
    logic [HIST_AW-1:0] wr_addr;
    logic [HIST_AW-1:0] last_slot;
    logic [HIST_AW:0]   fill;
  } hist_ctl_t;

endpackage

FILE: rtl/fdm_lane.sv
// One path lane: private delay line, interpolation, gain and saturation.
module fdm_lane (
  input  logic                          clk,
  input  fdm_pkg::hist_ctl_t            ctl,
  input  fdm_pkg::sample_t              wr_data,
  input  logic [fdm_pkg::DELAY_W-1:0]   delay,
  input  logic [fdm_pkg::GAIN_W-1:0]    gain,
  output fdm_pkg::sample_t              image
);
  import fdm_pkg::*;

  sample_t hist_mem [HIST_DEPTH];

  logic [DELAY_W-1:0]     delay_sat;
  logic [GAIN_W-1:0]      gain_sat;
  logic [HIST_AW-1:0]     age;
  logic [FRAC_BITS-1:0]   frac;
  logic [FRAC_BITS:0]     wgt_a;
  logic [HIST_AW-1:0]     addr_a;
  logic [HIST_AW-1:0]     addr_b;
  logic                   ok_a;
  logic                   ok_b;
  logic [P_W-1:0]         rnd;
  logic signed [SH_W-1:0] shifted;

  sample_t                rd_a_r;
  sample_t                rd_b_r;
  logic                   ok_a_r;
  logic                   ok_b_r;
  logic [FRAC_BITS-1:0]   frac_r;
  logic [FRAC_BITS:0]     wgt_a_r;
  logic signed [PA_W-1:0] pa_r;
  logic signed [PA_W-1:0] pb_r;
  logic signed [PA_W-1:0] v_r;
  logic signed [P_W-1:0]  prod_r;
  sample_t                image_r;

  always_comb begin
    delay_sat = (delay > MAX_DELAY) ? MAX_DELAY : delay;
    gain_sat  = (gain > GAIN_UNITY) ? GAIN_UNITY : gain;
    age       = delay_sat[DELAY_W-1:FRAC_BITS];
    frac      = delay_sat[FRAC_BITS-1:0];
    wgt_a     = (FRAC_BITS + 1)'(1 << FRAC_BITS) - {1'b0, frac};
    addr_a    = ctl.last_slot - age;
    addr_b    = ctl.last_slot - age - HIST_AW'(1);
    ok_a      = {1'b0, age} < ctl.fill;
    ok_b      = ({1'b0, age} + (HIST_AW + 1)'(1)) < ctl.fill;
    rnd       = prod_r + ROUND_BIAS;
    shifted   = rnd[P_W-1:SHIFT];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      hist_mem[ctl.wr_addr] <= wr_data;
    end
    rd_a_r <= hist_mem[addr_a];
    rd_b_r <= hist_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    ok_a_r  <= ok_a;
    ok_b_r  <= ok_b;
    frac_r  <= frac;
    wgt_a_r <= wgt_a;
    pa_r    <= ok_a_r ? rd_a_r * $signed({1'b0, wgt_a_r}) : $signed(PA_W'(0));
    pb_r    <= ok_b_r ? rd_b_r * $signed({1'b0, frac_r}) : $signed(PA_W'(0));
    v_r     <= pa_r + pb_r;
    prod_r  <= v_r * $signed({1'b0, gain_sat});
    if (shifted > SAT_HI) begin
      image_r <= SAT_HI[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      image_r <= SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      image_r <= shifted[SAMPLE_BITS-1:0];
    end
  end

  assign image = image_r;

endmodule

FILE: rtl/fdm_merge.sv
// Merge stage: mic sums and the output register.
module fdm_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  fdm_pkg::sample_t           images [fdm_pkg::NUM_PATHS],
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [fdm_pkg::OUT_W-1:0]  out_tdata
);
  import fdm_pkg::*;

  logic               valid_r;
  logic [OUT_W-1:0]   data_r;
  logic [MIX_W-1:0]   mix0;
  logic [MIX_W-1:0]   mix1;

  always_comb begin
    mix0 = MIX_W'(images[0]) + MIX_W'(images[2]);
    mix1 = MIX_W'(images[1]) + MIX_W'(images[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= OUT_W'({mix1, mix0, images[3], images[2], images[1], images[0]});
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

FILE: rtl/fractional_delay_two_mic_mixer.sv
// Top level of the fractional-delay two-source two-mic mixer.
// One request carries a sample of each source; the block returns one result of four
// delayed, interpolated and scaled path images plus the two mic sums. Each of the four
// path lanes keeps its own delay line and reads both neighbor samples in the same cycle.
// An item passes the lane pipeline (read, weight, sum, gain, round), then the output
// register, which loads only while empty or being drained; the next request is taken once
// the result enters it, so one request is in flight at a time. A fill count marks which
// history entries were written since reset, so no clearing pass is needed.
// Configuration writes are taken in any cycle after reset.
module fractional_delay_two_mic_mixer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] sample_src0, [31:16] sample_src1
  input  logic [fdm_pkg::IN_W-1:0]       in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] image_s0_m0, [31:16] image_s0_m1, [47:32] image_s1_m0,
  // [63:48] image_s1_m1, [80:64] mix_mic0, [97:81] mix_mic1, [103:98] zero
  output logic [fdm_pkg::OUT_W-1:0]      out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdm_pkg::DELAY_W-1:0]    cfg_data
);
  import fdm_pkg::*;

  localparam logic [2:0] PIPE_DONE = 3'd5;

  logic [DELAY_W-1:0] delay_r [NUM_PATHS];
  logic [GAIN_W-1:0]  gain_r  [NUM_PATHS];
  logic [HIST_AW-1:0] slot_r;
  logic [HIST_AW:0]   fill_r;
  logic               busy_r;
  logic [2:0]         cnt_r;
  logic [2:0]         cnt_nxt;

  logic               in_acc;
  logic               load;
  hist_ctl_t          ctl;
  sample_t            samples [2];
  sample_t            images  [NUM_PATHS];

  assign in_tready = rst_n && !busy_r;
  assign cfg_ready = rst_n;
  assign in_acc    = in_tvalid && in_tready;
  assign load      = busy_r && (cnt_r == PIPE_DONE) && (!out_tvalid || out_tready);
  assign cnt_nxt   = (cnt_r == PIPE_DONE) ? cnt_r : cnt_r + 3'd1;

  assign samples[0] = in_tdata[SAMPLE_BITS-1:0];
  assign samples[1] = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  always_comb begin
    ctl.wr_en     = in_acc;
    ctl.wr_addr   = slot_r;
    ctl.last_slot = slot_r - HIST_AW'(1);
    ctl.fill      = fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      fill_r <= '0;
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (in_acc) begin
        slot_r <= slot_r + HIST_AW'(1);
        if (fill_r != FILL_MAX) begin
          fill_r <= fill_r + (HIST_AW + 1)'(1);
        end
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_nxt;
        if (load) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PATHS; k++) begin
        delay_r[k] <= '0;
        gain_r[k]  <= GAIN_UNITY;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELAY_S0_M0: delay_r[0] <= cfg_data;
        REG_DELAY_S0_M1: delay_r[1] <= cfg_data;
        REG_DELAY_S1_M0: delay_r[2] <= cfg_data;
        REG_DELAY_S1_M1: delay_r[3] <= cfg_data;
        REG_GAIN_S0_M0:  gain_r[0]  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_S0_M1:  gain_r[1]  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_S1_M0:  gain_r[2]  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_S1_M1:  gain_r[3]  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar p = 0; p < NUM_PATHS; p++) begin : g_lane
    fdm_lane u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .wr_data (samples[p / 2]),
      .delay   (delay_r[p]),
      .gain    (gain_r[p]),
      .image   (images[p])
    );
  end

  fdm_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .images     (images),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/fdm_checker.sv
// Port-level checks of the mixer, bound to the top level.
module fdm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [fdm_pkg::OUT_W-1:0] out_tdata
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while a request is in flight");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a request in flight");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared right after a request was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind fractional_delay_two_mic_mixer fdm_checker u_fdm_checker (.*);
